// ===== rtl/beta_binomial_log_bayes_factor_unit_assert.svh =====
// Assertion macros used by the log Bayes factor unit.
`ifndef BETA_BINOMIAL_LOG_BAYES_FACTOR_UNIT_ASSERT_SVH
`define BETA_BINOMIAL_LOG_BAYES_FACTOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BBLBF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BBLBF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bblbf_pkg.sv =====
package bblbf_pkg;

   localparam int PRIOR_BITS = 44;
   localparam int IQ         = 28;
   localparam int DIV_QBITS  = 36;
   localparam int NUM_COEF   = 6;
   localparam int NUM_LGAM   = 6;

   localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

   localparam logic [31:0]        LN2_Q32      = 32'd2977044472;
   localparam logic signed [63:0] LNRT2PI_Q28  = 64'sd246675684;
   localparam logic signed [63:0] SER_C1       = 64'sd268435456;
   localparam logic signed [63:0] HALF_Q28     = 64'sd134217728;
   localparam logic signed [63:0] FIVEHALF_Q28 = 64'sd1476395008;

   // Lanczos coefficients, magnitude and sign, Q.28
   localparam logic [34:0] COEF_MAG [NUM_COEF] = '{
      35'd20449437662, 35'd23221095109, 35'd6446235412,
      35'd330642574, 35'd324445, 35'd1448
   };
   localparam logic COEF_NEG [NUM_COEF] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

   // lnG(x+a) + lnG(n-x-a+s) - lnG(n+s) - lnG(a) - lnG(s-a) + lnG(s)
   localparam logic TERM_NEG [NUM_LGAM] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
      return s[63:0];
   endfunction

endpackage

// ===== rtl/bblbf_mul.sv =====
module bblbf_mul (
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [63:0] product_ff
);

   always_ff @(posedge clock) begin
      product_ff <= 64'(op_a) * 64'(op_b);
   end

endmodule

// ===== rtl/bblbf_div.sv =====
module bblbf_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [63:0]                    dividend,
   input  logic [63:0]                    divisor,
   output logic [bblbf_pkg::DIV_QBITS-1:0] quotient_ff,
   output logic                           done_ff
);
   import bblbf_pkg::*;

   localparam int CNT_BITS = $clog2(DIV_QBITS + 1);

   logic [63:0]          rem_ff;
   logic [63:0]          den_ff;
   logic [DIV_QBITS-1:0] sh_ff;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic                 busy_ff;
   logic [64:0]          trial;

   assign trial = {rem_ff, sh_ff[DIV_QBITS-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            // top bits already below the divisor: quotient fits DIV_QBITS
            rem_ff  <= dividend >> DIV_QBITS;
            sh_ff   <= dividend[DIV_QBITS-1:0];
            den_ff  <= divisor;
            cnt_ff  <= CNT_BITS'(DIV_QBITS);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (trial >= {1'b0, den_ff}) begin
               rem_ff      <= 64'(trial - {1'b0, den_ff});
               quotient_ff <= {quotient_ff[DIV_QBITS-2:0], 1'b1};
            end else begin
               rem_ff      <= trial[63:0];
               quotient_ff <= {quotient_ff[DIV_QBITS-2:0], 1'b0};
            end
            sh_ff  <= sh_ff << 1;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

// ===== rtl/beta_binomial_log_bayes_factor_unit.sv =====
// Beta-binomial log-likelihood accumulator.
// req channel: one transaction per term. tdata holds successes, trials,
// prior_shape, prior_total (Q20.24); tuser = subtract_term; tlast = last_term.
// rsp channel: one transaction per term marked last, carrying the running
// sum (signed Q39.24, saturating) in tdata and the domain error flag in tuser.
// Each term runs six log-gamma evaluations on one 36-step restoring divider
// and one registered 32x32 multiplier under a single sequencer. A log-gamma
// takes six divisions plus three logarithms (normalize, 32 squarings) and a
// 4-partial-product multiply. A term with a non-positive gamma argument
// skips the evaluations and sets the error flag. req_tready is high only
// while idle. The result sits in an output register; if the receiver stalls,
// a following last term waits in its final state until the register frees.
// Reset (synchronous, active high) clears the sum, the error flag and any
// pending result.
module beta_binomial_log_bayes_factor_unit #(
   parameter int COUNT_BITS = 24,
   parameter int FRAC_BITS  = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // successes, trials, prior_shape, prior_total, zero padding
   input  logic [((2*COUNT_BITS+2*bblbf_pkg::PRIOR_BITS+7)/8)*8-1:0] req_tdata,
   input  logic req_tuser,   // subtract_term
   input  logic req_tlast,   // last_term
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic signed [63:0] rsp_tdata,  // log_factor
   output logic rsp_tuser                 // error_code
);
   import bblbf_pkg::*;
   `include "beta_binomial_log_bayes_factor_unit_assert.svh"

   localparam int N_LSB = COUNT_BITS;
   localparam int A_LSB = 2 * COUNT_BITS;
   localparam int S_LSB = 2 * COUNT_BITS + PRIOR_BITS;
   localparam int PLSH  = (FRAC_BITS <= IQ) ? IQ - FRAC_BITS : 0;
   localparam int PRSH  = (FRAC_BITS > IQ) ? FRAC_BITS - IQ : 0;
   localparam logic signed [63:0] OUT_LIM = S64_MAX >>> PRSH;

   typedef enum logic [4:0] {
      S_IDLE, S_START, S_LG_INIT, S_DIV_START, S_DIV_WAIT, S_SER_DONE,
      S_LN_START, S_LN_NORM, S_LN_SQ, S_LN_SQW, S_LN_K, S_LN_KW, S_LN_RET,
      S_UM_ISSUE, S_UM_ACC, S_UM_DONE, S_LG_SUBZF, S_LG_ADDC,
      S_T_ACC, S_Q_OUT, S_SUM, S_FIN
   } state_type;

   typedef enum logic [1:0] {R_ZF, R_SER, R_Z} ret_type;

   state_type            state_ff;
   ret_type              ret_ff;
   logic signed [63:0]   arg_ff [NUM_LGAM];
   logic [2:0]           li_ff;
   logic [2:0]           k_ff;
   logic signed [63:0]   z_ff, ser_ff, lg_ff, t_ff, sum_ff;
   logic signed [63:0]   ln_arg_ff, ln_ff, zh_ff;
   logic [63:0]          u_ff;
   logic [5:0]           p_ff;
   logic [30:0]          mant_ff;
   logic [31:0]          frac_ff;
   logic [4:0]           sq_ff;
   logic [1:0]           pp_ff;
   logic [127:0]         acc_ff;
   logic                 sub_ff, last_ff, err_ff;
   logic                 rsp_valid_ff, rsp_err_ff;
   logic signed [63:0]   rsp_data_ff;

   logic [31:0]          mul_a, mul_b;
   logic [63:0]          mul_p;
   logic                 div_start, div_done;
   logic [DIV_QBITS-1:0] div_q;
   logic [63:0]          div_num, div_den;

   logic signed [63:0]   xq, nq, aq, sq;
   logic [31:0]          m2;
   logic signed [7:0]    kval;
   logic signed [40:0]   kl;
   logic signed [63:0]   l32;
   logic [127:0]         pp_term;
   logic                 accept, dom_err, emit;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

   // last term loads the output register this cycle
   assign emit = (state_ff == S_FIN) && last_ff && (!rsp_valid_ff || rsp_tready);

   assign xq = 64'(req_tdata[COUNT_BITS-1:0]) << IQ;
   assign nq = 64'(req_tdata[N_LSB +: COUNT_BITS]) << IQ;
   assign aq = (64'(req_tdata[A_LSB +: PRIOR_BITS]) << PLSH) >> PRSH;
   assign sq = (64'(req_tdata[S_LSB +: PRIOR_BITS]) << PLSH) >> PRSH;

   always_comb begin
      dom_err = 1'b0;
      for (int i = 0; i < NUM_LGAM; i++) begin
         if (arg_ff[i][63] || arg_ff[i] == '0) dom_err = 1'b1;
      end
   end

   assign div_start = (state_ff == S_DIV_START);
   assign div_num   = 64'(COEF_MAG[k_ff]) << IQ;
   assign div_den   = 64'(z_ff) + ((64'(k_ff) + 64'd1) << IQ);

   bblbf_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .dividend    (div_num),
      .divisor     (div_den),
      .quotient_ff (div_q),
      .done_ff     (div_done)
   );

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_LN_SQ: begin
            mul_a = {1'b0, mant_ff};
            mul_b = {1'b0, mant_ff};
         end
         S_LN_K: begin
            mul_a = frac_ff;
            mul_b = LN2_Q32;
         end
         S_UM_ISSUE: begin
            mul_a = pp_ff[1] ? zh_ff[63:32] : zh_ff[31:0];
            mul_b = pp_ff[0] ? ln_ff[63:32] : ln_ff[31:0];
         end
         default: ;
      endcase
   end

   bblbf_mul u_mul (
      .clock      (clock),
      .op_a       (mul_a),
      .op_b       (mul_b),
      .product_ff (mul_p)
   );

   assign m2   = mul_p[61:30];
   assign kval = $signed({2'b00, p_ff}) - 8'sd28;
   assign kl   = kval * $signed({9'b0, LN2_Q32});
   assign l32  = $signed({{23{kl[40]}}, kl}) + $signed({32'b0, mul_p[63:32]});

   always_comb begin
      case (2'(pp_ff[1]) + 2'(pp_ff[0]))
         2'd0:    pp_term = {64'b0, mul_p};
         2'd1:    pp_term = {32'b0, mul_p, 32'b0};
         default: pp_term = {mul_p, 64'b0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         err_ff       <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !emit) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  arg_ff[0] <= xq + aq;
                  arg_ff[1] <= nq - xq - aq + sq;
                  arg_ff[2] <= nq + sq;
                  arg_ff[3] <= aq;
                  arg_ff[4] <= sq - aq;
                  arg_ff[5] <= sq;
                  sub_ff    <= req_tuser;
                  last_ff   <= req_tlast;
                  state_ff  <= S_START;
               end
            end
            S_START: begin
               if (dom_err) begin
                  err_ff   <= 1'b1;
                  state_ff <= S_FIN;
               end else begin
                  t_ff     <= '0;
                  li_ff    <= '0;
                  state_ff <= S_LG_INIT;
               end
            end
            S_LG_INIT: begin
               z_ff     <= arg_ff[li_ff];
               ser_ff   <= SER_C1;
               k_ff     <= '0;
               state_ff <= S_DIV_START;
            end
            S_DIV_START: state_ff <= S_DIV_WAIT;
            S_DIV_WAIT: begin
               if (div_done) begin
                  ser_ff <= COEF_NEG[k_ff] ? ser_ff - 64'(div_q) : ser_ff + 64'(div_q);
                  if (k_ff == 3'(NUM_COEF - 1)) begin
                     state_ff <= S_SER_DONE;
                  end else begin
                     k_ff     <= k_ff + 1'b1;
                     state_ff <= S_DIV_START;
                  end
               end
            end
            S_SER_DONE: begin
               if (ser_ff[63] || ser_ff == '0) ser_ff <= 64'sd1;
               ln_arg_ff <= z_ff + FIVEHALF_Q28;
               zh_ff     <= z_ff + HALF_Q28;
               ret_ff    <= R_ZF;
               state_ff  <= S_LN_START;
            end
            S_LN_START: begin
               if (ln_arg_ff[63] || ln_arg_ff == '0) begin
                  ln_ff    <= '0;
                  state_ff <= S_LN_RET;
               end else begin
                  u_ff     <= ln_arg_ff;
                  p_ff     <= 6'd63;
                  state_ff <= S_LN_NORM;
               end
            end
            S_LN_NORM: begin
               // leading-one search, a byte at a time while the top byte is clear, else a bit at a time
               if (u_ff[63]) begin
                  mant_ff  <= u_ff[63:33];
                  frac_ff  <= '0;
                  sq_ff    <= '0;
                  state_ff <= S_LN_SQ;
               end else if (u_ff[63:56] == '0) begin
                  u_ff <= u_ff << 8;
                  p_ff <= p_ff - 6'd8;
               end else begin
                  u_ff <= u_ff << 1;
                  p_ff <= p_ff - 6'd1;
               end
            end
            S_LN_SQ: state_ff <= S_LN_SQW;
            S_LN_SQW: begin
               if (m2[31]) begin
                  mant_ff <= m2[31:1];
                  frac_ff <= {frac_ff[30:0], 1'b1};
               end else begin
                  mant_ff <= m2[30:0];
                  frac_ff <= {frac_ff[30:0], 1'b0};
               end
               sq_ff    <= sq_ff + 1'b1;
               state_ff <= (sq_ff == 5'd31) ? S_LN_K : S_LN_SQ;
            end
            S_LN_K: state_ff <= S_LN_KW;
            S_LN_KW: begin
               ln_ff    <= l32 >>> (32 - IQ);
               state_ff <= S_LN_RET;
            end
            S_LN_RET: begin
               case (ret_ff)
                  R_ZF: begin
                     acc_ff   <= '0;
                     pp_ff    <= '0;
                     state_ff <= S_UM_ISSUE;
                  end
                  R_SER: begin
                     lg_ff     <= sat_add(lg_ff, ln_ff);
                     ln_arg_ff <= z_ff;
                     ret_ff    <= R_Z;
                     state_ff  <= S_LN_START;
                  end
                  default: begin
                     lg_ff    <= sat_sub(lg_ff, ln_ff);
                     state_ff <= S_T_ACC;
                  end
               endcase
            end
            S_UM_ISSUE: state_ff <= S_UM_ACC;
            S_UM_ACC: begin
               acc_ff   <= acc_ff + pp_term;
               pp_ff    <= pp_ff + 1'b1;
               state_ff <= (pp_ff == 2'd3) ? S_UM_DONE : S_UM_ISSUE;
            end
            S_UM_DONE: begin
               lg_ff    <= (acc_ff[127:99] != '0) ? S64_MAX : $signed(acc_ff[91:28]);
               state_ff <= S_LG_SUBZF;
            end
            S_LG_SUBZF: begin
               lg_ff    <= sat_sub(lg_ff, ln_arg_ff);
               state_ff <= S_LG_ADDC;
            end
            S_LG_ADDC: begin
               lg_ff     <= sat_add(lg_ff, LNRT2PI_Q28);
               ln_arg_ff <= ser_ff;
               ret_ff    <= R_SER;
               state_ff  <= S_LN_START;
            end
            S_T_ACC: begin
               t_ff <= TERM_NEG[li_ff] ? sat_sub(t_ff, lg_ff) : sat_add(t_ff, lg_ff);
               if (li_ff == 3'(NUM_LGAM - 1)) begin
                  state_ff <= S_Q_OUT;
               end else begin
                  li_ff    <= li_ff + 1'b1;
                  state_ff <= S_LG_INIT;
               end
            end
            S_Q_OUT: begin
               if (PRSH == 0)             t_ff <= t_ff >>> PLSH;
               else if (t_ff > OUT_LIM)   t_ff <= S64_MAX;
               else if (t_ff < -OUT_LIM - 64'sd1) t_ff <= S64_MIN;
               else                       t_ff <= t_ff <<< PRSH;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               sum_ff   <= sub_ff ? sat_sub(sum_ff, t_ff) : sat_add(sum_ff, t_ff);
               state_ff <= S_FIN;
            end
            S_FIN: begin
               if (!last_ff) begin
                  state_ff <= S_IDLE;
               end else if (emit) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= sum_ff;
                  rsp_err_ff   <= err_ff;
                  sum_ff       <= '0;
                  err_ff       <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `BBLBF_ASSERT_NXT(a_busy_after_accept, clock, reset, accept, !req_tready, "ready after accept")
   `BBLBF_ASSERT_NXT(a_hold_pending, clock, reset, (state_ff == S_FIN) && last_ff && rsp_valid_ff && !rsp_tready, (state_ff == S_FIN) && rsp_valid_ff, "pending result overwritten")
   `BBLBF_ASSERT_IMP(a_div_done_state, clock, reset, div_done, state_ff == S_DIV_WAIT, "divider done outside wait")

endmodule

// ===== tb/tb_beta_binomial_log_bayes_factor_unit.sv =====
`timescale 1ns / 100ps

module tb_beta_binomial_log_bayes_factor_unit;
   import bblbf_pkg::*;

   localparam int COUNT_W     = 24;
   localparam int FRAC_W      = 24;
   localparam int TDATA_W     = ((2*COUNT_W+2*PRIOR_BITS+7)/8)*8;
   localparam int RANDOM_TERMS = 1230;
   localparam int IDLE_LIMIT  = 40000;
   localparam int HOLD_CYCLES = 9000;
   localparam logic [43:0] ONE_Q = 44'h100_0000;
   localparam logic [43:0] PRIOR_MAX = {44{1'b1}};
   localparam logic [23:0] COUNT_MAX = {24{1'b1}};

   typedef struct {
      logic [23:0] successes;
      logic [23:0] trials;
      logic [43:0] prior_shape;
      logic [43:0] prior_total;
      logic        subtract_term;
      logic        last_term;
   } term_t;

   typedef struct {
      logic signed [63:0] log_factor;
      logic               error_code;
   } factor_t;

   typedef struct {
      term_t   term;
      logic    typed;
      factor_t want;
   } directed_row_t;

   logic clock, reset;
   logic req_tvalid, req_tready, req_tuser, req_tlast;
   logic [TDATA_W-1:0] req_tdata;
   logic rsp_tvalid, rsp_tready, rsp_tuser;
   logic signed [63:0] rsp_tdata;

   factor_t            pending_factors[$];
   directed_row_t      directed_rows[$];
   logic signed [63:0] model_sum;
   logic               model_domain_err;
   int                 mismatches;
   int                 factors_seen;
   int                 idle_cycles;

   beta_binomial_log_bayes_factor_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic signed [63:0] clamp_add(input logic signed [63:0] a,
                                                    input logic signed [63:0] b,
                                                    input logic neg);
      logic signed [64:0] s;
      s = neg ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return S64_MAX;
      if (s < -65'sh0_8000_0000_0000_0000) return S64_MIN;
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] fixed_ln(input logic signed [63:0] v);
      logic [63:0] u, m, f;
      int p;
      logic signed [63:0] k, l32;
      if (v <= 0) return 0;
      u = v;
      p = 63;
      while (p > 0 && !u[p]) p--;
      m = (p >= 30) ? (u >> (p - 30)) : (u << (30 - p));
      f = '0;
      for (int i = 31; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= 64'h8000_0000) begin
            m = m >> 1;
            f[i] = 1'b1;
         end
      end
      k = p - IQ;
      l32 = k * $signed({32'd0, LN2_Q32}) + $signed((f * {32'd0, LN2_Q32}) >> 32);
      return l32 >>> (32 - IQ);
   endfunction

   function automatic logic signed [63:0] lanczos_lgamma(input logic signed [63:0] z);
      logic signed [63:0] ser, zf, zh, lg;
      logic [127:0] num, quo, prod;
      logic [63:0] d;
      ser = SER_C1;
      for (int k = 0; k < NUM_COEF; k++) begin
         d = z + (64'(k + 1) << IQ);
         num = 128'(COEF_MAG[k]) << IQ;
         quo = num / 128'(d);
         ser = COEF_NEG[k] ? ser - $signed(quo[63:0]) : ser + $signed(quo[63:0]);
      end
      if (ser < 1) ser = 1;
      zf = z + FIVEHALF_Q28;
      zh = z + HALF_Q28;
      prod = 128'(zh) * 128'(fixed_ln(zf));
      prod = prod >> IQ;
      // saturate only when the full product reaches bit 99
      lg = (prod[127:71] != '0) ? S64_MAX : $signed(prod[63:0]);
      lg = clamp_add(lg, zf, 1'b1);
      lg = clamp_add(lg, LNRT2PI_Q28, 1'b0);
      lg = clamp_add(lg, fixed_ln(ser), 1'b0);
      lg = clamp_add(lg, fixed_ln(z), 1'b1);
      return lg;
   endfunction

   // advance the running log factor; returns 1 when the term closes a frame
   function automatic logic accumulate_term(input term_t t, output factor_t f);
      logic signed [63:0] xq, nq, a, s, a1, b1, s1, b0, v;
      xq = 64'(t.successes) << IQ;
      nq = 64'(t.trials) << IQ;
      a  = 64'(t.prior_shape) << (IQ - FRAC_W);
      s  = 64'(t.prior_total) << (IQ - FRAC_W);
      a1 = xq + a;
      b1 = nq - xq - a + s;
      s1 = nq + s;
      b0 = s - a;
      if (a1 <= 0 || b1 <= 0 || s1 <= 0 || a <= 0 || b0 <= 0 || s <= 0) begin
         model_domain_err = 1'b1;
      end else begin
         v = lanczos_lgamma(a1);
         v = clamp_add(v, lanczos_lgamma(b1), 1'b0);
         v = clamp_add(v, lanczos_lgamma(s1), 1'b1);
         v = clamp_add(v, lanczos_lgamma(a), 1'b1);
         v = clamp_add(v, lanczos_lgamma(b0), 1'b1);
         v = clamp_add(v, lanczos_lgamma(s), 1'b0);
         v = v >>> (IQ - FRAC_W);
         model_sum = clamp_add(model_sum, v, t.subtract_term);
      end
      f.log_factor = model_sum;
      f.error_code = model_domain_err;
      if (t.last_term) begin
         model_sum = '0;
         model_domain_err = 1'b0;
      end
      return t.last_term;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // offer one term; hold valid until it is taken
   task automatic send_term(input term_t t, input int gap, input logic typed,
                            input factor_t want);
      factor_t f;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {{(TDATA_W-136){1'b0}}, t.prior_total, t.prior_shape,
                     t.trials, t.successes};
      req_tuser  <= t.subtract_term;
      req_tlast  <= t.last_term;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (accumulate_term(t, f)) pending_factors.push_back(typed ? want : f);
      @(negedge clock);
   endtask

   function automatic term_t random_term(input logic last);
      term_t t;
      int r;
      r = $urandom_range(0, 99);
      t.subtract_term = 1'($urandom_range(0, 1));
      t.last_term = last;
      if (r < 8) begin
         t.successes   = 24'($urandom);
         t.trials      = 24'($urandom);
         t.prior_shape = 44'({$urandom, $urandom});
         t.prior_total = 44'({$urandom, $urandom});
      end else if (r < 16) begin
         t.trials      = 24'($urandom_range(0, 500));
         t.successes   = 24'($urandom_range(0, t.trials));
         t.prior_shape = (r < 12) ? 44'd0 : 44'($urandom_range(1, 1 << 28));
         t.prior_total = (r < 12) ? 44'($urandom) : t.prior_shape - 44'($urandom_range(0, 9));
      end else begin
         t.trials = (r < 21) ? 24'($urandom) : 24'($urandom_range(0, 2000));
         t.successes = 24'($urandom_range(0, t.trials));
         t.prior_shape = 44'($urandom_range(1 << 14, 1 << 30));
         t.prior_total = t.prior_shape + 44'($urandom_range(1, 1 << 30))
                         + ((r > 96) ? {12'($urandom_range(0, 4095)), 32'd0} : 44'd0);
      end
      return t;
   endfunction

   task automatic add_row(input logic [23:0] x, input logic [23:0] n,
                          input logic [43:0] a, input logic [43:0] s,
                          input logic sub, input logic last, input logic typed,
                          input logic signed [63:0] sum, input logic err);
      directed_row_t row;
      row.term = '{x, n, a, s, sub, last};
      row.typed = typed;
      row.want = '{sum, err};
      directed_rows.push_back(row);
   endtask

   initial begin
      term_t   t;
      factor_t none;
      int burst, gap, frame_left;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      req_tlast  <= 1'b0;
      reset      <= 1'b1;
      model_sum = '0;
      model_domain_err = 1'b0;
      none = '{64'sd0, 1'b0};

      // empty counts cancel exactly
      add_row(0, 0, ONE_Q, 2*ONE_Q, 0, 1, 1, 0, 0);
      // domain errors: zero shape, shape equal to total, zero total, x past n
      add_row(3, 9, 0, ONE_Q, 0, 1, 1, 0, 1);
      add_row(3, 9, ONE_Q, ONE_Q, 0, 1, 1, 0, 1);
      add_row(0, 0, 0, 0, 1, 1, 1, 0, 1);
      add_row(COUNT_MAX, 0, ONE_Q, 2*ONE_Q, 0, 1, 1, 0, 1);
      // add then subtract the same term
      add_row(5, 10, ONE_Q, 2*ONE_Q, 0, 0, 0, 0, 0);
      add_row(5, 10, ONE_Q, 2*ONE_Q, 1, 1, 1, 0, 0);
      add_row(COUNT_MAX, COUNT_MAX, ONE_Q, 2*ONE_Q, 0, 1, 0, 0, 0);
      add_row(0, COUNT_MAX, ONE_Q, 2*ONE_Q, 1, 1, 0, 0, 0);
      add_row(1, 2, 44'd1, 44'd2, 0, 1, 0, 0, 0);
      add_row(7, 9, PRIOR_MAX - 1, PRIOR_MAX, 0, 1, 0, 0, 0);
      add_row(COUNT_MAX, COUNT_MAX, ONE_Q, PRIOR_MAX, 1, 1, 0, 0, 0);
      add_row(2, 4, ONE_Q, ONE_Q, 0, 0, 0, 0, 0);
      add_row(17, 40, ONE_Q / 2, 3*ONE_Q, 0, 1, 0, 0, 0);
      add_row(3, 7, ONE_Q / 2, 3*ONE_Q, 1, 0, 0, 0, 0);
      add_row(1, 20, 2*ONE_Q, 5*ONE_Q, 0, 0, 0, 0, 0);
      add_row(12, 30, 3*ONE_Q, 4*ONE_Q, 1, 1, 0, 0, 0);

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_term(directed_rows[i].term, $urandom_range(0, 2),
                   directed_rows[i].typed, directed_rows[i].want);

      burst = 0;
      frame_left = $urandom_range(1, 8);
      for (int i = 0; i < RANDOM_TERMS; i++) begin
         gap = 0;
         if (burst == 0) begin
            burst = $urandom_range(1, 25);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         end
         burst--;
         frame_left--;
         t = random_term(frame_left == 0 || i == RANDOM_TERMS - 1);
         if (frame_left == 0) frame_left = $urandom_range(1, 8);
         send_term(t, gap, 1'b0, none);
      end
      req_tvalid <= 1'b0;

      while (pending_factors.size() != 0) @(posedge clock);
      repeat (3200) @(posedge clock);
      if (mismatches == 0 && pending_factors.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // receiver: rotating stall patterns plus one long hold-off
   initial begin
      int cyc;
      logic held;
      cyc = 0;
      held = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         if (!held && factors_seen >= 4) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            case ((cyc / 700) % 3)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= cyc[1];
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      factor_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         factors_seen <= factors_seen + 1;
         if (pending_factors.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_tdata, 64'd0);
         end else begin
            want = pending_factors.pop_front();
            if (rsp_tdata !== want.log_factor)
               report_mismatch("log_factor", rsp_tdata, want.log_factor);
            if (rsp_tuser !== want.error_code)
               report_mismatch("error_code", 64'(rsp_tuser), 64'(want.error_code));
         end
      end
   end

   initial begin
      mismatches = 0;
      factors_seen = 0;
      idle_cycles = 0;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bblbf_pkg.sv
rtl/bblbf_mul.sv
rtl/bblbf_div.sv
rtl/beta_binomial_log_bayes_factor_unit.sv
tb/tb_beta_binomial_log_bayes_factor_unit.sv
